>>> rtl/twcs_pkg.sv
// shared types and constants for the textured wall column stepper
package twcs_pkg;

    typedef struct packed {
        logic        kind;
        logic [11:0] column;
        logic [23:0] distance;
        logic        side;
        logic signed [15:0] sin_of_angle;
        logic signed [15:0] cos_of_angle;
        logic [23:0] player_x;
        logic [23:0] player_y;
    } t_in_item;

    typedef struct packed {
        logic [11:0] screen_column;
        logic [11:0] screen_row;
        logic [19:0] texel_index;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [11:0] data;
    } t_cfg_item;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TEX_WIDTH     = 3'd2;
    localparam logic [2:0] REG_TEX_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_MAP_SCALE     = 3'd4;

    localparam int unsigned WALL_BITS  = 24;
    localparam int unsigned TRIG_FRAC  = 14;
    localparam int unsigned POS_FRAC   = 8;
    localparam int unsigned DIV_BITS   = 64;

endpackage

>>> rtl/twcs_if.sv
// valid/ready channel interfaces for items and configuration writes
interface twcs_in_if;
    import twcs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface twcs_out_if;
    import twcs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface twcs_cfg_if;
    import twcs_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/twcs_divider.sv
// shared restoring divider, one quotient bit per cycle
module twcs_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [twcs_pkg::DIV_BITS-1:0] i_num,
    input  logic [31:0]               i_den,
    output logic                      o_done,
    output logic [twcs_pkg::DIV_BITS-1:0] o_quot,
    output logic [31:0]               o_rem
);
    import twcs_pkg::*;

    logic [DIV_BITS-1:0] r_quot;
    logic [32:0]         r_rem;
    logic [31:0]         r_den;
    logic [6:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [32:0]         trial;
    logic [32:0]         shifted;

    always_comb begin
        shifted = {r_rem[31:0], r_quot[DIV_BITS-1]};
        trial   = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 7'(DIV_BITS);
            end else if (r_busy) begin
                if (!trial[32]) begin
                    r_rem  <= trial;
                    r_quot <= {r_quot[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted;
                    r_quot <= {r_quot[DIV_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[31:0];
endmodule

>>> rtl/textured_wall_column_stepper_core.sv
// top level of the textured wall column stepper
// A column item (kind 0) makes two passes through the shared 64-step
// divider (wall height, then scaled player position), then multiplies and
// clamps. A tick item (kind 1) on an active column makes one divider pass
// for texture y, and its row is held in an output register until taken.
// A tick with no active column, or a column off screen, gives nothing.
// i_in.ready is low while an item is at work or a result waits.
module textured_wall_column_stepper_core #(
    parameter int DIST_FRAC_BITS = 12,
    parameter int COORD_BITS     = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    twcs_in_if.sink    i_in,
    twcs_out_if.source o_out,
    twcs_cfg_if.sink   i_cfg
);
    import twcs_pkg::*;

    localparam int WPOS_FRAC = DIST_FRAC_BITS + TRIG_FRAC;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WALL_GO, ST_WALL_WAIT, ST_POS_GO, ST_POS_WAIT,
        ST_TEX_MUL, ST_TEX_FIN, ST_TICK_MUL, ST_TICK_GO, ST_TICK_WAIT,
        ST_TICK_OUT, ST_HOLD
    } t_state;

    t_state r_state;

    // configuration registers
    logic [11:0] r_screen_width, r_screen_height;
    logic [10:0] r_tex_width, r_tex_height;
    logic [7:0]  r_map_scale;

    // column state
    logic                  r_active;
    logic [COORD_BITS-1:0] r_cur_col, r_row, r_end_row;
    logic signed [24:0]    r_ustart;
    logic [23:0]           r_wall_rows;
    logic [9:0]            r_tex_x;

    // latched item
    t_in_item r_item;
    logic signed [63:0] r_w;
    logic [47:0]        r_prod;
    logic [34:0]        r_rel_mul;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    // shared divider
    logic                div_start;
    logic [DIV_BITS-1:0] div_num, div_quot;
    logic [31:0]         div_den, div_rem;
    logic                div_done;

    twcs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    // position numerator ((pos - 0.5 px) scaled) is signed; divide magnitude
    logic               pos_side;
    logic [23:0]        pos_sel;
    logic signed [63:0] pos_num;
    logic [63:0]        pos_mag;
    logic [7:0]         scale_eff;
    logic signed [63:0] pos_q;
    logic signed [63:0] dist_trig;
    logic [WPOS_FRAC-1:0] frac;
    logic [11:0]        tx_raw, tx_mir, tx_lim;
    logic               mirror;
    logic [11:0]        half_h;
    logic [24:0]        en_full;
    logic signed [25:0] us_full;
    logic [24:0]        st_full;
    logic [23:0]        rel;
    logic [30:0]        ty_w;

    always_comb begin
        pos_side  = r_item.side;
        pos_sel   = pos_side ? r_item.player_x : r_item.player_y;
        pos_num   = ($signed({40'd0, pos_sel}) - 64'sd128) <<< (WPOS_FRAC - POS_FRAC);
        pos_mag   = pos_num[63] ? 64'(-pos_num) : 64'(pos_num);
        scale_eff = (r_map_scale == 8'd0) ? 8'd1 : r_map_scale;
        // floor division from truncated magnitude division
        if (!pos_num[63])
            pos_q = $signed(div_quot);
        else if (div_rem != 32'd0)
            pos_q = -$signed(div_quot) - 64'sd1;
        else
            pos_q = -$signed(div_quot);
        dist_trig = $signed({40'd0, r_item.distance}) *
                    64'(pos_side ? r_item.cos_of_angle : r_item.sin_of_angle);
        frac   = r_w[WPOS_FRAC-1:0];
        tx_raw = 12'(r_prod >> WPOS_FRAC);
        mirror = (!pos_side && r_item.cos_of_angle[15]) ||
                 (pos_side && !r_item.sin_of_angle[15] && r_item.sin_of_angle != 16'sd0);
        tx_mir = mirror ? 12'({1'b0, r_tex_width} - 12'd1 - tx_raw) : tx_raw;
        tx_lim = (r_tex_width > 11'd1024) ? 12'd1023 : 12'({1'b0, r_tex_width} - 12'd1);
        half_h = {1'b0, r_screen_height[11:1]};
        en_full = 25'(half_h) + 25'(r_wall_rows[23:1]);
        us_full = $signed(26'(half_h)) - $signed(26'(r_wall_rows[23:1]));
        st_full = us_full[25] ? 25'd0 : us_full[24:0];
        // row offset from the unclipped top can reach the full wall height
        rel  = 24'($signed({{(25-COORD_BITS){1'b0}}, r_row}) - r_ustart);
        ty_w = 31'(div_quot);
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            ST_WALL_GO: begin
                div_start = 1'b1;
                div_num   = DIV_BITS'({r_screen_height, {DIST_FRAC_BITS{1'b0}}});
                div_den   = 32'(r_item.distance);
            end
            ST_POS_GO: begin
                div_start = 1'b1;
                div_num   = pos_mag;
                div_den   = 32'(scale_eff);
            end
            ST_TICK_GO: begin
                div_start = 1'b1;
                div_num   = DIV_BITS'(r_rel_mul);
                div_den   = 32'(r_wall_rows);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_screen_width  <= 12'd1920;
            r_screen_height <= 12'd1080;
            r_tex_width     <= 11'd64;
            r_tex_height    <= 11'd64;
            r_map_scale     <= 8'd32;
            r_active        <= 1'b0;
            r_cur_col       <= '0;
            r_row           <= '0;
            r_end_row       <= '0;
            r_ustart        <= '0;
            r_wall_rows     <= '0;
            r_tex_x         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg.data.data;
                    REG_SCREEN_HEIGHT: r_screen_height <= i_cfg.data.data;
                    REG_TEX_WIDTH:     r_tex_width     <= i_cfg.data.data[10:0];
                    REG_TEX_HEIGHT:    r_tex_height    <= i_cfg.data.data[10:0];
                    REG_MAP_SCALE:     r_map_scale     <= i_cfg.data.data[7:0];
                    default: ;
                endcase
            end
            if (o_out.ready && r_out_valid)
                r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_item <= i_in.data;
                        if (!i_in.data.kind) begin
                            r_active <= 1'b0;
                            if (i_in.data.column < r_screen_width)
                                r_state <= ST_WALL_GO;
                        end else if (r_active) begin
                            r_state <= ST_TICK_MUL;
                        end
                    end
                end
                ST_WALL_GO:   r_state <= ST_WALL_WAIT;
                ST_WALL_WAIT: begin
                    if (div_done) begin
                        // zero distance and overflow both saturate
                        if (r_item.distance == 24'd0 || div_quot > 64'hFF_FFFF)
                            r_wall_rows <= 24'hFF_FFFF;
                        else
                            r_wall_rows <= div_quot[23:0];
                        r_state <= ST_POS_GO;
                    end
                end
                ST_POS_GO:   r_state <= ST_POS_WAIT;
                ST_POS_WAIT: begin
                    if (div_done) begin
                        r_w     <= pos_q + dist_trig;
                        r_state <= ST_TEX_MUL;
                    end
                end
                ST_TEX_MUL: begin
                    r_prod  <= 48'(frac) * 48'(r_tex_width);
                    r_state <= ST_TEX_FIN;
                end
                ST_TEX_FIN: begin
                    if (r_tex_width == 11'd0)
                        r_tex_x <= '0;
                    else if (tx_mir > tx_lim)
                        r_tex_x <= tx_lim[9:0];
                    else
                        r_tex_x <= tx_mir[9:0];
                    r_cur_col <= r_item.column[COORD_BITS-1:0];
                    r_ustart  <= us_full[24:0];
                    r_row     <= st_full[COORD_BITS-1:0];
                    if (en_full > 25'(r_screen_height)) begin
                        r_end_row <= r_screen_height[COORD_BITS-1:0];
                        r_active  <= st_full < 25'(r_screen_height);
                    end else begin
                        r_end_row <= en_full[COORD_BITS-1:0];
                        r_active  <= st_full < en_full;
                    end
                    r_state <= ST_IDLE;
                end
                ST_TICK_MUL: begin
                    r_rel_mul <= 35'(rel) * 35'(r_tex_height);
                    r_state   <= ST_TICK_GO;
                end
                ST_TICK_GO:   r_state <= ST_TICK_WAIT;
                ST_TICK_WAIT: begin
                    if (div_done) begin
                        r_prod  <= 48'(ty_w) * 48'(r_tex_width);
                        r_state <= ST_TICK_OUT;
                    end
                end
                ST_TICK_OUT: begin
                    r_out.screen_column <= 12'(r_cur_col);
                    r_out.screen_row    <= 12'(r_row);
                    r_out.texel_index   <= 20'(r_prod + 48'(r_tex_x));
                    r_out.last          <= (13'(r_row) + 13'd1) >= 13'(r_end_row);
                    r_out_valid         <= 1'b1;
                    if ((13'(r_row) + 13'd1) >= 13'(r_end_row))
                        r_active <= 1'b0;
                    r_row   <= r_row + 1'b1;
                    r_state <= ST_HOLD;
                end
                ST_HOLD: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> verif/tb_top.sv
// self-checking testbench for the textured wall column stepper core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import twcs_pkg::*;

    localparam int  LIMIT_CYCLES  = 1500000;
    localparam int  SETTLE_CYCLES = 300;
    localparam int  PHASE_ITEMS   = 440;
    localparam bit  KIND_COLUMN   = 1'b0;
    localparam bit  KIND_TICK     = 1'b1;

    logic i_clk;
    logic i_rst_n;

    twcs_in_if  in_ch();
    twcs_out_if out_ch();
    twcs_cfg_if cfg_ch();

    textured_wall_column_stepper_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // stimulus and expected rows
    t_in_item  pending_items[$];
    t_out_item expected_rows[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        send_hold;
    int        error_count;
    int        cycle_count;

    // predictor copy of the registers
    bit [11:0] sw_reg, sh_reg;
    bit [10:0] tw_reg, th_reg;
    bit [7:0]  scale_reg;

    // predictor copy of the slice state
    bit        slice_active;
    bit [11:0] slice_column, slice_row, slice_end;
    longint    slice_start;
    bit [23:0] slice_rows;
    bit [9:0]  slice_tex_x;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // column load: wall height, clipping and texture column
    function automatic void load_slice(t_in_item it);
        longint h, wh, half_h, us, en, st, pos, trig, scale, num, w, frac, tw, tx, lim;
        slice_active = 0;
        if (it.column >= sw_reg)
            return;
        h = sh_reg;
        if (it.distance == 0) begin
            wh = 24'hFFFFFF;
        end else begin
            wh = (h << 12) / longint'(it.distance);
            if (wh > 24'hFFFFFF)
                wh = 24'hFFFFFF;
        end
        half_h = h / 2;
        us = half_h - wh / 2;
        en = half_h + wh / 2;
        if (en > h)
            en = h;
        st = (us < 0) ? 0 : us;
        // side 0 walks along y with sine, side 1 along x with cosine
        pos = it.side ? longint'(it.player_x) : longint'(it.player_y);
        trig = it.side ? longint'(it.cos_of_angle) : longint'(it.sin_of_angle);
        scale = (scale_reg != 0) ? longint'(scale_reg) : 1;
        num = (pos << 18) - (longint'(128) << 18);
        w = floor_div(num, scale) + longint'(it.distance) * trig;
        frac = w & ((longint'(1) << 26) - 1);
        tw = tw_reg;
        tx = 0;
        if (tw != 0) begin
            tx = (frac * tw) >> 26;
            if ((!it.side && it.cos_of_angle < 0) || (it.side && it.sin_of_angle > 0))
                tx = tw - tx - 1;
            lim = ((tw > 1024) ? 1024 : tw) - 1;
            if (tx > lim)
                tx = lim;
        end
        slice_column = it.column;
        slice_rows   = wh[23:0];
        slice_start  = us;
        slice_row    = st[11:0];
        slice_end    = en[11:0];
        slice_tex_x  = tx[9:0];
        slice_active = st < en;
    endfunction

    function automatic void predict_wall_slice(t_in_item it);
        longint    rel, ty, texel;
        t_out_item row_item;
        if (it.kind == KIND_COLUMN) begin
            load_slice(it);
            return;
        end
        // tick with no slice gives nothing
        if (!slice_active)
            return;
        rel = longint'(slice_row) - slice_start;
        ty = 0;
        if (slice_rows != 0 && th_reg != 0)
            ty = (rel * longint'(th_reg)) / longint'(slice_rows);
        texel = ty * longint'(tw_reg) + longint'(slice_tex_x);
        row_item.screen_column = slice_column;
        row_item.screen_row    = slice_row;
        row_item.texel_index   = texel[19:0];
        row_item.last          = (longint'(slice_row) + 1) >= longint'(slice_end);
        expected_rows.push_back(row_item);
        slice_row = slice_row + 12'd1;
        if (row_item.last)
            slice_active = 0;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("textured_wall_column_stepper_core test failed");
            $finish;
        end
    end

    // item driver: holds an offered item until taken, predicts on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_wall_slice(in_ch.data);
                void'(pending_items.pop_front());
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (pending_items.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_items[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back pressure
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row, actual %p", $realtime, out_ch.data);
                    error_count = error_count + 1;
                end else begin
                    want = expected_rows.pop_front();
                    if (out_ch.data.screen_column !== want.screen_column) begin
                        $display("%0t: screen_column expected %0d actual %0d", $realtime,
                                 want.screen_column, out_ch.data.screen_column);
                        error_count = error_count + 1;
                    end
                    if (out_ch.data.screen_row !== want.screen_row) begin
                        $display("%0t: screen_row expected %0d actual %0d", $realtime,
                                 want.screen_row, out_ch.data.screen_row);
                        error_count = error_count + 1;
                    end
                    if (out_ch.data.texel_index !== want.texel_index) begin
                        $display("%0t: texel_index expected %0d actual %0d", $realtime,
                                 want.texel_index, out_ch.data.texel_index);
                        error_count = error_count + 1;
                    end
                    if (out_ch.data.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d", $realtime,
                                 want.last, out_ch.data.last);
                        error_count = error_count + 1;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // block idle: nothing queued, nothing expected, then the longest load time
    task automatic wait_idle();
        wait (pending_items.size() == 0 && !in_ch.valid);
        wait (expected_rows.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, data: value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_SCREEN_WIDTH:  sw_reg    = value;
            REG_SCREEN_HEIGHT: sh_reg    = value;
            REG_TEX_WIDTH:     tw_reg    = value[10:0];
            REG_TEX_HEIGHT:    th_reg    = value[10:0];
            REG_MAP_SCALE:     scale_reg = value[7:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_view(int sw, int sh, int tw, int th, int ms);
        write_reg(REG_SCREEN_WIDTH, 12'(sw));
        write_reg(REG_SCREEN_HEIGHT, 12'(sh));
        write_reg(REG_TEX_WIDTH, 12'(tw));
        write_reg(REG_TEX_HEIGHT, 12'(th));
        write_reg(REG_MAP_SCALE, 12'(ms));
    endtask

    function automatic t_in_item column_item(int col, int hit_dist, bit sd, int sn, int cs,
                                             int px, int py);
        t_in_item it;
        it.kind = KIND_COLUMN;
        it.column = 12'(col);
        it.distance = 24'(hit_dist);
        it.side = sd;
        it.sin_of_angle = 16'(sn);
        it.cos_of_angle = 16'(cs);
        it.player_x = 24'(px);
        it.player_y = 24'(py);
        return it;
    endfunction

    function automatic t_in_item tick_item();
        t_in_item it;
        it = column_item($urandom_range(4095), $urandom, $urandom_range(1),
                         int'($urandom_range(32768)) - 16384,
                         int'($urandom_range(32768)) - 16384, $urandom, $urandom);
        it.kind = KIND_TICK;
        return it;
    endfunction

    function automatic void add_ticks(int n);
        repeat (n) pending_items.push_back(tick_item());
    endfunction

    // distance picked so walls span from the full screen down to nothing
    function automatic int pick_distance();
        case ($urandom_range(9))
            0:       return 0;
            1, 2:    return $urandom_range(24'hFFFFFF);
            3, 4:    return $urandom_range(4095);
            default: return (int'(sh_reg) << 12) / $urandom_range(1, 24);
        endcase
    endfunction

    // one load with random content followed by a run of ticks
    function automatic void add_random_column();
        int col;
        col = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                       : $urandom_range((sw_reg > 0) ? sw_reg - 1 : 0);
        pending_items.push_back(column_item(col, pick_distance(), $urandom_range(1),
                                int'($urandom_range(32768)) - 16384,
                                int'($urandom_range(32768)) - 16384,
                                $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF)));
        add_ticks(($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12));
    endfunction

    task automatic run_random(int send_pct, int recv_pct, bit pause_midway);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (pending_items.size() < PHASE_ITEMS / 2) add_random_column();
        if (pause_midway) begin
            // hold the sender until every row in flight has come back
            wait (pending_items.size() < PHASE_ITEMS / 4);
            send_hold = 1;
            wait (expected_rows.size() == 0 && !in_ch.valid);
            repeat (20) @(posedge i_clk);
            send_hold = 0;
        end
        while (pending_items.size() < PHASE_ITEMS / 2) add_random_column();
        wait_idle();
    endtask

    initial begin
        in_ch.valid  = 0;
        in_ch.data   = '0;
        out_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.data  = '0;
        send_hold    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count  = 0;
        cycle_count  = 0;
        sw_reg = 1920; sh_reg = 1080; tw_reg = 64; th_reg = 64; scale_reg = 32;
        slice_active = 0; slice_column = 0; slice_row = 0; slice_end = 0;
        slice_start = 0; slice_rows = 0; slice_tex_x = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // directed: small screen so slices stay short
        set_view(1920, 16, 64, 64, 32);
        add_ticks(1);                                          // tick with no slice
        pending_items.push_back(column_item(5, 0, 0, 100, -200, 0, 24'hFFFFFF));
        add_ticks(17);                                         // zero distance, full clip
        pending_items.push_back(column_item(4095, 4096, 1, 0, 0, 0, 0));
        add_ticks(1);                                          // off-screen column
        pending_items.push_back(column_item(1919, 24'hFFFFFF, 0, 16384, 16384, 0, 0));
        add_ticks(1);                                          // far wall, empty slice
        pending_items.push_back(column_item(0, 8192, 1, 16384, -16384, 24'hFFFFFF, 0));
        add_ticks(2);
        pending_items.push_back(column_item(7, 16384, 1, -16384, 0, 300, 700));
        add_ticks(2);                                          // load while active
        wait_idle();

        run_random(0, 0, 1);
        set_view(4095, 2, 1, 1, 1);
        run_random(83, 0, 0);
        set_view(1, 4095, 1024, 1024, 255);
        run_random(0, 83, 1);
        set_view(640, 96, 0, 0, 0);
        run_random(32, 32, 0);
        set_view($urandom_range(1, 4095), $urandom_range(2, 200), 2047,
                 $urandom_range(1, 1024), $urandom_range(1, 255));
        run_random(0, 0, 0);
        set_view($urandom_range(1, 4095), $urandom_range(2, 200), $urandom_range(1, 1024),
                 $urandom_range(1, 1024), $urandom_range(1, 255));
        run_random(32, 32, 1);

        if (error_count == 0) begin
            $display("textured_wall_column_stepper_core test passed");
        end else begin
            $display("textured_wall_column_stepper_core test failed");
        end
        $finish;
    end
endmodule
